@@ sv/lfu_cache_core_macros.svh @@
// ---------------------------------------------------------------------------
// lfu cache core assertion macros
// concurrent assertion wrappers, clocked on clock and disabled in reset
// ---------------------------------------------------------------------------
`ifndef LFU_CACHE_CORE_MACROS_SVH
`define LFU_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LFU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LFU_ASSERT_SAME(lbl, ante, cons, msg)
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/lfu_pkg.sv @@
// ---------------------------------------------------------------------------
// lfu cache package
// sizes, widths, request codes and sequencer state type of the lfu cache core
// ---------------------------------------------------------------------------
package lfu_pkg;

   // store geometry
   localparam int ENTRIES    = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int OCC_W      = $clog2(ENTRIES + 1);
   localparam int COUNT_BITS = 16;

   // fixed field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // request codes
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

@@ sv/lfu_cache_core.sv @@
// ---------------------------------------------------------------------------
// lfu cache core
// fully associative key/value store, least-frequently-used replacement with
// least-recently-used tie break, scanned one entry per cycle by one compare unit
// ---------------------------------------------------------------------------
// a request is latched at the accepting edge, scanned in ST_SCAN and applied in ST_UPDATE,
//    and rsp_valid is registered from ST_UPDATE; a new request is accepted only in ST_IDLE,
//    after the entry scan through the single key/count compare unit and the update cycle
// busy is high in the scan and update states and falls in the cycle of the response
//    strobe, which lasts one cycle and cannot be stalled
// reset: synchronous, clears all entry valid bits and occupancy and sets capacity to 16
`include "lfu_cache_core_macros.svh"

module lfu_cache_core
   import lfu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic signed [KEY_W-1:0] req_lookup_key,
   input  logic signed [VAL_W-1:0] req_write_value,
   // response channel
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_evicted,
   output logic signed [KEY_W-1:0] rsp_evicted_key,
   // capacity register write
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CAP_W-1:0]        csr_wdata
);

   // entry store
   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_W-1:0]      key_ff   [ENTRIES];
   logic [VAL_W-1:0]      data_ff  [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];
   logic [IDX_W-1:0]      rank_ff  [ENTRIES];
   logic [OCC_W-1:0]      occ_ff;
   logic [CAP_W-1:0]      capacity_ff;

   // sequencer
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff;
   logic                  accept, scan_en, upd_en, scan_last;

   // latched request
   logic                  op_ff;
   logic [KEY_W-1:0]      req_key_ff;
   logic [VAL_W-1:0]      req_val_ff;

   // scan results
   logic                  m_found_ff, v_found_ff, f_found_ff;
   logic [IDX_W-1:0]      m_idx_ff, v_idx_ff, f_idx_ff;
   logic [VAL_W-1:0]      m_data_ff;
   logic [COUNT_BITS-1:0] m_cnt_ff, v_cnt_ff;
   logic [IDX_W-1:0]      m_rank_ff, v_rank_ff;
   logic [KEY_W-1:0]      v_key_ff;

   // response registers
   logic                  rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [VAL_W-1:0]      rsp_read_value_ff;
   logic [KEY_W-1:0]      rsp_evicted_key_ff;

   // shared compare unit signals
   logic                  cur_valid, cur_match, cur_better;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic [IDX_W-1:0]      cur_rank;

   // update decisions
   logic [OCC_W-1:0]      cap_eff;
   logic                  get_hit, put_hit, put_new, do_evict, do_fill, do_touch, do_insert;
   logic [IDX_W-1:0]      t_slot;
   logic [OCC_W-1:0]      t_rank;
   logic [COUNT_BITS-1:0] bumped_cnt;

   // ------------------------------------------------------------------
   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_SCAN;
         ST_SCAN:   if (scan_last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy    = 1'b1;
      scan_en = 1'b0;
      upd_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy    = 1'b0;
         ST_SCAN:   scan_en = 1'b1;
         ST_UPDATE: upd_en  = 1'b1;
         default:   busy    = 1'b1;
      endcase
   end

   assign accept    = start && !busy;
   assign scan_last = (idx_ff == IDX_W'(ENTRIES - 1));
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (accept) begin
         idx_ff <= '0;
      end else if (scan_en) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // request word latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_action;
         req_key_ff <= req_lookup_key;
         req_val_ff <= req_write_value;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(16);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // shared compare unit: one entry per cycle during the scan
   assign cur_valid  = valid_ff[idx_ff];
   assign cur_cnt    = count_ff[idx_ff];
   assign cur_rank   = rank_ff[idx_ff];
   assign cur_match  = cur_valid && (key_ff[idx_ff] == req_key_ff);
   assign cur_better = cur_valid &&
                       (!v_found_ff || (cur_cnt < v_cnt_ff) ||
                        ((cur_cnt == v_cnt_ff) && (cur_rank > v_rank_ff)));

   // scan result tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         m_found_ff <= 1'b0;
         v_found_ff <= 1'b0;
         f_found_ff <= 1'b0;
      end else if (accept) begin
         m_found_ff <= 1'b0;
         v_found_ff <= 1'b0;
         f_found_ff <= 1'b0;
      end else if (scan_en) begin
         if (cur_match && !m_found_ff) m_found_ff <= 1'b1;
         if (cur_better) v_found_ff <= 1'b1;
         if (!cur_valid && !f_found_ff) f_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_en) begin
         if (cur_match && !m_found_ff) begin
            m_idx_ff  <= idx_ff;
            m_data_ff <= data_ff[idx_ff];
            m_cnt_ff  <= cur_cnt;
            m_rank_ff <= cur_rank;
         end
         if (cur_better) begin
            v_idx_ff  <= idx_ff;
            v_cnt_ff  <= cur_cnt;
            v_rank_ff <= cur_rank;
            v_key_ff  <= key_ff[idx_ff];
         end
         if (!cur_valid && !f_found_ff) begin
            f_idx_ff <= idx_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // update decisions
   assign cap_eff  = (capacity_ff > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES)
                                                     : OCC_W'(capacity_ff);
   assign get_hit  = (op_ff == ACT_GET) && m_found_ff;
   assign put_hit  = (op_ff == ACT_PUT) && (cap_eff != '0) && m_found_ff;
   assign put_new  = (op_ff == ACT_PUT) && (cap_eff != '0) && !m_found_ff;
   assign do_evict = put_new && (occ_ff >= cap_eff) && v_found_ff;
   assign do_fill  = put_new && !do_evict && f_found_ff;
   assign do_touch = get_hit || put_hit;
   assign do_insert = do_evict || do_fill;

   // slot that moves to the front and the rank it leaves behind
   always_comb begin
      priority if (do_touch) begin
         t_slot = m_idx_ff;
         t_rank = OCC_W'(m_rank_ff);
      end else if (do_evict) begin
         t_slot = v_idx_ff;
         t_rank = OCC_W'(v_rank_ff);
      end else begin
         t_slot = f_idx_ff;
         t_rank = occ_ff;
      end
   end

   // saturating use count bump
   assign bumped_cnt = (&m_cnt_ff) ? m_cnt_ff : m_cnt_ff + COUNT_BITS'(1);

   // entry valid bits and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (upd_en && do_insert) begin
         valid_ff[t_slot] <= 1'b1;
         if (do_fill) occ_ff <= occ_ff + OCC_W'(1);
      end
   end

   // key, data and count of the chosen slot
   always_ff @(posedge clock) begin
      if (upd_en) begin
         if (do_insert) begin
            key_ff[t_slot]   <= req_key_ff;
            data_ff[t_slot]  <= req_val_ff;
            count_ff[t_slot] <= COUNT_BITS'(1);
         end else if (do_touch) begin
            count_ff[t_slot] <= bumped_cnt;
            if (put_hit) data_ff[t_slot] <= req_val_ff;
         end
      end
   end

   // recency ranks: entries more recent than the moved slot age by one
   always_ff @(posedge clock) begin
      if (upd_en && (do_touch || do_insert)) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == t_slot) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && (OCC_W'(rank_ff[i]) < t_rank)) begin
               rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= upd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en) begin
         rsp_hit_ff     <= m_found_ff;
         rsp_evicted_ff <= do_evict;
         if (op_ff == ACT_PUT) begin
            rsp_read_value_ff <= '0;
         end else if (m_found_ff) begin
            rsp_read_value_ff <= m_data_ff;
         end else begin
            rsp_read_value_ff <= '1;
         end
         rsp_evicted_key_ff <= do_evict ? v_key_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   // ------------------------------------------------------------------
   // checks
   `LFU_ASSERT_SAME(a_occ_tracks_valid, 1'b1, $countones(valid_ff) == occ_ff, "occupancy off")
   `LFU_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "strobe too long")
   `LFU_ASSERT_SAME(a_evict_on_miss, rsp_valid && rsp_evicted, !rsp_hit, "evict on hit")
   `LFU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !rsp_valid, "busy not raised")

endmodule
